// ===== src/lct_pkg.sv =====
package lct_pkg;

   // link count and counter width
   localparam int LINKS      = 5;
   localparam int COUNT_BITS = 32;

   // index and population widths
   localparam int LINK_W       = $clog2(LINKS);
   localparam int POP_W        = $clog2(LINKS + 1);
   localparam int CMD_W        = 3;
   localparam int LINK_FIELD_W = 3;

   // event codes as they arrive on the request port
   localparam logic [CMD_W-1:0] CMD_TX_START  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RX_END    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DROP_END  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DROP_ONLY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TX_END    = 3'd4;
   // internal op for an unknown command or a link out of range
   localparam logic [CMD_W-1:0] OP_IGNORE     = 3'd5;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [LINKS-1:0]      mask_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [LINK_FIELD_W-1:0] link;
   } req_type;

   typedef struct packed {
      logic [4:0]              active_mask;
      logic                    solo_start;
      logic                    lone_valid;
      logic [LINK_FIELD_W-1:0] lone_link;
      logic                    pair_found;
      logic [LINK_FIELD_W-1:0] pair_first;
      logic [LINK_FIELD_W-1:0] pair_second;
      logic [31:0]             pair_total;
      logic [31:0]             tx_total;
      logic [31:0]             rx_total;
      logic [31:0]             drop_total;
      logic [31:0]             solo_total;
   } rsp_type;

   // classified event as handed from front to back
   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [LINK_W-1:0] link;
   } work_type;

   localparam count_type CNT_MAX = '1;

   function automatic count_type sat_inc(input count_type c);
      sat_inc = (c == CNT_MAX) ? c : c + count_type'(1);
   endfunction

   // two increments at once, for the diagonal of the pair table
   function automatic count_type sat_add2(input count_type c);
      sat_add2 = (c >= CNT_MAX - count_type'(1)) ? CNT_MAX : c + count_type'(2);
   endfunction

   function automatic logic [POP_W-1:0] popcount(input mask_type m);
      logic [POP_W-1:0] n;
      n = '0;
      for (int k = 0; k < LINKS; k++) begin
         n = n + POP_W'(m[k]);
      end
      popcount = n;
   endfunction

   function automatic logic [LINK_W-1:0] top_bit(input mask_type m);
      logic [LINK_W-1:0] idx;
      idx = '0;
      for (int k = 0; k < LINKS; k++) begin
         if (m[k]) begin
            idx = LINK_W'(k);
         end
      end
      top_bit = idx;
   endfunction

endpackage

// ===== src/lct_front.sv =====
module lct_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lct_pkg::req_type  req_data,
   output logic              work_valid,
   output lct_pkg::work_type work_head,
   input  logic              work_take
);

   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   lct_pkg::work_type entry_ff [2];
   lct_pkg::work_type classified;
   logic              accept;
   logic              take;

   // unknown commands and links beyond the table collapse to one ignore op
   always_comb begin
      classified.link = lct_pkg::LINK_W'(req_data.link);
      if (req_data.cmd inside {[lct_pkg::CMD_TX_START:lct_pkg::CMD_TX_END]} &&
          int'(req_data.link) < lct_pkg::LINKS) begin
         classified.op = req_data.cmd;
      end else begin
         classified.op = lct_pkg::OP_IGNORE;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign accept     = push && !full;
   assign work_valid = (count_ff != 2'd0);
   assign take       = work_take && work_valid;
   assign work_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== src/lct_rsp_queue.sv =====
module lct_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_push,
   input  lct_pkg::rsp_type res_data,
   output logic             res_space,
   output logic             empty,
   input  logic             pop,
   output lct_pkg::rsp_type rsp_data
);

   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   lct_pkg::rsp_type entry_ff [2];
   logic             take;
   logic             store;

   assign res_space = (count_ff != 2'd2);
   assign store     = res_push && res_space;
   assign empty     = (count_ff == 2'd0);
   assign take      = pop && !empty;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = store ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, store} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         entry_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

// ===== src/lct_back.sv =====
module lct_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              work_valid,
   input  lct_pkg::work_type work_head,
   output logic              work_take,
   input  logic              res_space,
   output logic              res_push,
   output lct_pkg::rsp_type  res_data
);

   lct_pkg::mask_type  now_ff, prev_ff, prev2_ff;
   lct_pkg::mask_type  now_in;
   lct_pkg::count_type tx_ff   [lct_pkg::LINKS];
   lct_pkg::count_type solo_ff [lct_pkg::LINKS];
   lct_pkg::count_type lone_ff [lct_pkg::LINKS];
   lct_pkg::count_type rx_ff   [lct_pkg::LINKS];
   lct_pkg::count_type drop_ff [lct_pkg::LINKS];
   lct_pkg::count_type pair_ff [lct_pkg::LINKS][lct_pkg::LINKS];

   logic                          fire;
   logic                          valid_op, is_tx, is_rx, is_drop, is_mask;
   logic [lct_pkg::LINK_W-1:0]    lk;
   lct_pkg::mask_type             link_bit;
   logic [lct_pkg::POP_W-1:0]     now_pop;
   logic [lct_pkg::LINK_W-1:0]    now_top;
   logic                          solo_hit, lone_hit, pair_hit;
   logic [lct_pkg::LINK_W-1:0]    pi, pj;
   lct_pkg::count_type            pair_new;
   lct_pkg::count_type            tx_tot, rx_tot, drop_tot, solo_tot;

   assign fire      = work_valid && res_space;
   assign work_take = fire;
   assign res_push  = fire;

   always_comb begin
      lk       = work_head.link;
      valid_op = (work_head.op != lct_pkg::OP_IGNORE);
      is_tx    = (work_head.op == lct_pkg::CMD_TX_START);
      is_rx    = (work_head.op == lct_pkg::CMD_RX_END);
      is_drop  = (work_head.op == lct_pkg::CMD_DROP_END) ||
                 (work_head.op == lct_pkg::CMD_DROP_ONLY);
      is_mask  = valid_op && (work_head.op != lct_pkg::CMD_DROP_ONLY);
      link_bit = lct_pkg::mask_type'(1) << lk;

      now_pop = lct_pkg::popcount(now_ff);
      now_top = lct_pkg::top_bit(now_ff);

      // new mask; history shifts on every mask event
      if (is_mask) begin
         now_in = is_tx ? (now_ff | link_bit) : (now_ff & ~link_bit);
      end else begin
         now_in = now_ff;
      end

      // one alone, then several, then one alone again
      pair_hit = is_mask &&
                 (lct_pkg::popcount(prev_ff) == lct_pkg::POP_W'(1)) &&
                 (now_pop > lct_pkg::POP_W'(1)) &&
                 (lct_pkg::popcount(now_in) == lct_pkg::POP_W'(1));
      pi = lct_pkg::top_bit(now_in);
      pj = lct_pkg::top_bit(prev_ff);
      // table stays symmetric, so one read serves both entries
      pair_new = (pi == pj) ? lct_pkg::sat_add2(pair_ff[pi][pj])
                            : lct_pkg::sat_inc(pair_ff[pi][pj]);

      solo_hit = is_tx && (now_pop == lct_pkg::POP_W'(0));
      lone_hit = is_tx && (now_pop == lct_pkg::POP_W'(1));

      tx_tot   = is_tx ? lct_pkg::sat_inc(tx_ff[lk]) : tx_ff[lk];
      rx_tot   = is_rx ? lct_pkg::sat_inc(rx_ff[lk]) : rx_ff[lk];
      drop_tot = is_drop ? lct_pkg::sat_inc(drop_ff[lk]) : drop_ff[lk];
      solo_tot = solo_hit ? lct_pkg::sat_inc(solo_ff[lk]) : solo_ff[lk];
   end

   always_comb begin
      res_data             = '0;
      res_data.active_mask = 5'(now_in);
      if (valid_op) begin
         res_data.solo_start = solo_hit;
         res_data.lone_valid = lone_hit;
         res_data.lone_link  = lone_hit ? lct_pkg::LINK_FIELD_W'(now_top)
                                        : '0;
         res_data.pair_found = pair_hit;
         if (pair_hit) begin
            res_data.pair_first  = lct_pkg::LINK_FIELD_W'(pi);
            res_data.pair_second = lct_pkg::LINK_FIELD_W'(pj);
            res_data.pair_total  = 32'(pair_new);
         end
         res_data.tx_total   = 32'(tx_tot);
         res_data.rx_total   = 32'(rx_tot);
         res_data.drop_total = 32'(drop_tot);
         res_data.solo_total = 32'(solo_tot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         prev_ff  <= '0;
         prev2_ff <= '0;
         for (int k = 0; k < lct_pkg::LINKS; k++) begin
            tx_ff[k]   <= '0;
            solo_ff[k] <= '0;
            lone_ff[k] <= '0;
            rx_ff[k]   <= '0;
            drop_ff[k] <= '0;
            for (int m = 0; m < lct_pkg::LINKS; m++) begin
               pair_ff[k][m] <= '0;
            end
         end
      end else if (fire && valid_op) begin
         if (is_mask) begin
            prev2_ff <= prev_ff;
            prev_ff  <= now_ff;
            now_ff   <= now_in;
         end
         tx_ff[lk]   <= tx_tot;
         rx_ff[lk]   <= rx_tot;
         drop_ff[lk] <= drop_tot;
         solo_ff[lk] <= solo_tot;
         if (lone_hit) begin
            lone_ff[now_top] <= lct_pkg::sat_inc(lone_ff[now_top]);
         end
         if (pair_hit) begin
            pair_ff[pi][pj] <= pair_new;
            // diagonal entry already took both increments
            if (pi != pj) begin
               pair_ff[pj][pi] <= pair_new;
            end
         end
      end
   end

   // a counted pair always leaves exactly one link active
   assert property (@(posedge clock) disable iff (reset)
      fire && res_data.pair_found |-> $onehot(res_data.active_mask))
      else $error("pair counted without a single active link");

   // a start cannot find both no link and one link active
   assert property (@(posedge clock) disable iff (reset)
      fire |-> !(res_data.solo_start && res_data.lone_valid))
      else $error("solo and lone start flagged together");

   // ignored events leave the mask and its history alone
   assert property (@(posedge clock) disable iff (reset)
      fire && !valid_op |=> $stable(now_ff) && $stable(prev_ff) && $stable(prev2_ff))
      else $error("ignored event changed the mask history");

   // mask history shifts by one on each mask event
   assert property (@(posedge clock) disable iff (reset)
      fire && is_mask |=> prev_ff == $past(now_ff) && prev2_ff == $past(prev_ff))
      else $error("mask history did not shift");

endmodule

// ===== src/link_cotransmit_tracker.sv =====
// channel    | ports                       | direction | accepted when
// request    | push, full, req_data        | in        | push && !full
// response   | empty, pop, rsp_data        | out       | pop && !empty
//
// one request in per cycle sustained while responses are popped without gaps; a taken
// request is registered in the front queue, then, once the response queue has space,
// in the response queue, whose head drives rsp_data
// reset is synchronous and active high; it clears the masks, every counter
// and the pair table at once, and empties both queues
// a stalled response side fills the two-entry response queue, then the
// two-entry request queue, and only then raises full
module link_cotransmit_tracker (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             push,
   output logic             full,
   input  lct_pkg::req_type req_data,
   // response side
   output logic             empty,
   input  logic             pop,
   output lct_pkg::rsp_type rsp_data
);

   // front to back: classified event queue
   logic              work_valid;
   lct_pkg::work_type work_head;
   logic              work_take;

   // back to response queue
   logic              res_space;
   logic              res_push;
   lct_pkg::rsp_type  res_data;

   // front: decodes the event, folds bad commands and links into an ignore
   // op, and buffers up to two requests
   lct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_head  (work_head),
      .work_take  (work_take)
   );

   // back: mask history, per-link counters and pair table, one event a cycle while the response queue has space
   lct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_head  (work_head),
      .work_take  (work_take),
      .res_space  (res_space),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   // response queue lets the back part keep going while a result waits
   lct_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_space (res_space),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/lct_checker.sv =====
module lct_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  lct_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  lct_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               open_count
);

   lct_pkg::mask_type  mask_now, mask_prev, mask_prev2;
   lct_pkg::count_type tx_cnt[lct_pkg::LINKS];
   lct_pkg::count_type solo_cnt[lct_pkg::LINKS];
   lct_pkg::count_type lone_cnt[lct_pkg::LINKS];
   lct_pkg::count_type rx_cnt[lct_pkg::LINKS];
   lct_pkg::count_type drop_cnt[lct_pkg::LINKS];
   lct_pkg::count_type pair_cnt[lct_pkg::LINKS][lct_pkg::LINKS];

   lct_pkg::rsp_type due_reports[$];

   function automatic int unsigned ones_in(input lct_pkg::mask_type m);
      int unsigned n;
      n = 0;
      for (int k = 0; k < lct_pkg::LINKS; k++) begin
         n += m[k];
      end
      return n;
   endfunction

   // lone link of a mask is its highest set bit
   function automatic int unsigned highest_link(input lct_pkg::mask_type m);
      int unsigned idx;
      idx = 0;
      for (int k = 0; k < lct_pkg::LINKS; k++) begin
         if (m[k]) begin
            idx = k;
         end
      end
      return idx;
   endfunction

   function automatic void bump(inout lct_pkg::count_type c);
      if (c != {lct_pkg::COUNT_BITS{1'b1}}) begin
         c = c + 1'b1;
      end
   endfunction

   // history shift, bit update, then the single-many-single pair test
   function automatic void shift_mask(input int unsigned lk, input bit set,
                                      inout lct_pkg::rsp_type r);
      int unsigned i, j;
      mask_prev2 = mask_prev;
      mask_prev  = mask_now;
      if (set) begin
         mask_now = mask_now | (lct_pkg::mask_type'(1) << lk);
      end else begin
         mask_now = mask_now & ~(lct_pkg::mask_type'(1) << lk);
      end
      if (ones_in(mask_prev2) == 1 && ones_in(mask_now) == 1 && ones_in(mask_prev) > 1) begin
         i = highest_link(mask_now);
         j = highest_link(mask_prev2);
         bump(pair_cnt[i][j]);
         bump(pair_cnt[j][i]);
         r.pair_found  = 1'b1;
         r.pair_first  = lct_pkg::LINK_FIELD_W'(i);
         r.pair_second = lct_pkg::LINK_FIELD_W'(j);
         r.pair_total  = 32'(pair_cnt[i][j]);
      end
   endfunction

   function automatic lct_pkg::rsp_type track_event(input lct_pkg::req_type q);
      lct_pkg::rsp_type r;
      int unsigned      lk, busy, lone;
      r  = '0;
      lk = q.link;
      if (q.cmd <= lct_pkg::CMD_TX_END && lk < lct_pkg::LINKS) begin
         case (q.cmd)
            lct_pkg::CMD_TX_START: begin
               busy = ones_in(mask_now);
               bump(tx_cnt[lk]);
               if (busy == 0) begin
                  bump(solo_cnt[lk]);
                  r.solo_start = 1'b1;
               end else if (busy == 1) begin
                  lone = highest_link(mask_now);
                  bump(lone_cnt[lone]);
                  r.lone_valid = 1'b1;
                  r.lone_link  = lct_pkg::LINK_FIELD_W'(lone);
               end
               shift_mask(lk, 1'b1, r);
            end
            lct_pkg::CMD_RX_END: begin
               shift_mask(lk, 1'b0, r);
               bump(rx_cnt[lk]);
            end
            lct_pkg::CMD_DROP_END: begin
               bump(drop_cnt[lk]);
               shift_mask(lk, 1'b0, r);
            end
            lct_pkg::CMD_DROP_ONLY: begin
               bump(drop_cnt[lk]);
            end
            default: begin
               shift_mask(lk, 1'b0, r);
            end
         endcase
         r.tx_total   = 32'(tx_cnt[lk]);
         r.rx_total   = 32'(rx_cnt[lk]);
         r.drop_total = 32'(drop_cnt[lk]);
         r.solo_total = 32'(solo_cnt[lk]);
      end
      r.active_mask = 5'(mask_now);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      lct_pkg::rsp_type want;
      if (reset) begin
         mask_now   = '0;
         mask_prev  = '0;
         mask_prev2 = '0;
         for (int k = 0; k < lct_pkg::LINKS; k++) begin
            tx_cnt[k]   = '0;
            solo_cnt[k] = '0;
            lone_cnt[k] = '0;
            rx_cnt[k]   = '0;
            drop_cnt[k] = '0;
            for (int m = 0; m < lct_pkg::LINKS; m++) begin
               pair_cnt[k][m] = '0;
            end
         end
         due_reports.delete();
         fail_count = 0;
      end else begin
         if (pop && !empty) begin
            if (due_reports.size() == 0) begin
               $display("%0t response: expected none actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               check_field("active_mask", want.active_mask, rsp_data.active_mask);
               check_field("solo_start", want.solo_start, rsp_data.solo_start);
               check_field("lone_valid", want.lone_valid, rsp_data.lone_valid);
               check_field("lone_link", want.lone_link, rsp_data.lone_link);
               check_field("pair_found", want.pair_found, rsp_data.pair_found);
               check_field("pair_first", want.pair_first, rsp_data.pair_first);
               check_field("pair_second", want.pair_second, rsp_data.pair_second);
               check_field("pair_total", want.pair_total, rsp_data.pair_total);
               check_field("tx_total", want.tx_total, rsp_data.tx_total);
               check_field("rx_total", want.rx_total, rsp_data.rx_total);
               check_field("drop_total", want.drop_total, rsp_data.drop_total);
               check_field("solo_total", want.solo_total, rsp_data.solo_total);
            end
         end
         if (push && !full) begin
            due_reports.push_back(track_event(req_data));
         end
      end
      open_count = due_reports.size();
   end

endmodule

// ===== verif/tb_link_cotransmit_tracker.sv =====
module tb_link_cotransmit_tracker;

   localparam int PERIOD       = 12;
   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_ITEMS = 550;
   // receiver hold-off long enough to fill both internal queues
   localparam int LONG_HOLD    = 60;
   // command codes the block must ignore
   localparam logic [lct_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd5;
   localparam logic [lct_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd6;
   localparam logic [lct_pkg::CMD_W-1:0] CMD_RSVD_C = 3'd7;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             push     = 1'b0;
   logic             pop      = 1'b0;
   lct_pkg::req_type req_data = '0;
   logic             full, empty;
   lct_pkg::rsp_type rsp_data;
   int               fail_count, open_count;

   // set per stretch of items: no gaps at all on the request side
   bit sender_burst = 1'b0;

   always #(PERIOD / 2) clock = ~clock;

   link_cotransmit_tracker i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   lct_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   function automatic lct_pkg::req_type mk(input logic [lct_pkg::CMD_W-1:0] c,
                                           input int unsigned lk);
      lct_pkg::req_type q;
      q.cmd  = c;
      q.link = lct_pkg::LINK_FIELD_W'(lk);
      return q;
   endfunction

   // mostly real link events, with a tail of noise over the whole field space
   function automatic lct_pkg::req_type random_request();
      int unsigned pick, lk;
      pick = $urandom_range(0, 99);
      lk   = $urandom_range(0, lct_pkg::LINKS - 1);
      if (pick < 38) begin
         return mk(lct_pkg::CMD_TX_START, lk);
      end else if (pick < 58) begin
         return mk(lct_pkg::CMD_TX_END, lk);
      end else if (pick < 70) begin
         return mk(lct_pkg::CMD_RX_END, lk);
      end else if (pick < 80) begin
         return mk(lct_pkg::CMD_DROP_END, lk);
      end else if (pick < 86) begin
         return mk(lct_pkg::CMD_DROP_ONLY, lk);
      end
      return mk(lct_pkg::CMD_W'($urandom_range(0, 7)), $urandom_range(0, 7));
   endfunction

   // one request: optional gap, then hold push until the block takes it
   task automatic send_request(input lct_pkg::req_type item);
      int unsigned gap;
      gap = sender_burst ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // response side: random pops, idle-free stretches, one long hold-off
   initial begin
      int unsigned gap;
      int          taken;
      bit          burst;
      taken = 0;
      burst = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (taken % 40 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         gap = burst ? 0 : $urandom_range(0, 5);
         // block fills up and full rises while the sender keeps offering
         if (taken == 150) begin
            gap = LONG_HOLD;
         end
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         taken++;
      end
   end

   // request side and verdict
   initial begin
      int               sent;
      bit               paused;
      lct_pkg::req_type q;
      sent    = 0;
      paused  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // solo start, then a start credited to the link already active
      send_request(mk(lct_pkg::CMD_TX_START, 0));
      send_request(mk(lct_pkg::CMD_TX_START, 1));
      // back to one link: pair on the diagonal
      send_request(mk(lct_pkg::CMD_TX_END, 1));
      send_request(mk(lct_pkg::CMD_TX_START, lct_pkg::LINKS - 1));
      // back to one link, now a different one
      send_request(mk(lct_pkg::CMD_RX_END, 0));
      // start on a link that is already active
      send_request(mk(lct_pkg::CMD_TX_START, lct_pkg::LINKS - 1));
      send_request(mk(lct_pkg::CMD_TX_START, 2));
      send_request(mk(lct_pkg::CMD_DROP_END, lct_pkg::LINKS - 1));
      send_request(mk(lct_pkg::CMD_DROP_ONLY, 2));
      send_request(mk(lct_pkg::CMD_TX_START, 3));
      send_request(mk(lct_pkg::CMD_TX_START, 1));
      send_request(mk(lct_pkg::CMD_TX_END, 3));
      send_request(mk(lct_pkg::CMD_RX_END, 2));
      send_request(mk(lct_pkg::CMD_DROP_END, 1));
      // clearing a link that is not active
      send_request(mk(lct_pkg::CMD_RX_END, 0));
      // unknown commands and links out of range leave the state alone
      send_request(mk(CMD_RSVD_A, 0));
      send_request(mk(CMD_RSVD_B, 3));
      send_request(mk(CMD_RSVD_C, 7));
      send_request(mk(lct_pkg::CMD_TX_START, lct_pkg::LINKS));
      send_request(mk(lct_pkg::CMD_TX_START, 7));
      send_request(mk(lct_pkg::CMD_RX_END, 6));
      send_request(mk(lct_pkg::CMD_DROP_ONLY, 7));
      send_request(mk(lct_pkg::CMD_TX_START, lct_pkg::LINKS - 1));
      send_request(mk(lct_pkg::CMD_TX_END, lct_pkg::LINKS - 1));

      while (sent < RANDOM_ITEMS) begin
         if (sent % 40 == 0) begin
            sender_burst = ($urandom_range(0, 3) == 0);
         end
         // once, let the block drain completely before going on
         if (sent == 300 && !paused) begin
            paused = 1'b1;
            push <= 1'b0;
            @(negedge clock);
            while (open_count != 0) @(negedge clock);
            @(posedge clock);
         end
         q = random_request();
         send_request(q);
         sent++;
      end
      push <= 1'b0;

      // drain, then wait before the verdict
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(PERIOD * LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== link_cotransmit_tracker.f =====
src/lct_pkg.sv
src/lct_front.sv
src/lct_rsp_queue.sv
src/lct_back.sv
src/link_cotransmit_tracker.sv
verif/lct_checker.sv
verif/tb_link_cotransmit_tracker.sv
